// ===== design/utf8d_pkg.sv =====
package utf8d_pkg;

  // Default build-time bound on the character count of one string
  localparam int unsigned MAX_CHARS_DEF = 32'd65536;

  // Reset value of the output limit register
  localparam logic [16:0] CFG_RESET = 17'd65536;

  // Results one input byte can cause at most
  localparam int MAX_RES = 4;

  // Entries of the record queue between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam int CP_W = 21;

  // Sequence lengths named by lead byte
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // All results caused by one byte, in delivery order
  typedef struct packed {
    logic [2:0]                      cnt;
    logic                            last;
    logic [MAX_RES-1:0][CP_W-1:0]    cp;
  } utf8d_rec_t;

  // Data bits of a lead byte for a given sequence length
  function automatic logic [7:0] lead_mask(input logic [2:0] len);
    logic [7:0] m;
    unique case (len)
      SEQ_LEN4: m = 8'h07;
      SEQ_LEN3: m = 8'h0f;
      default:  m = 8'h1f;
    endcase
    return m;
  endfunction

  // Sequence length opened by a byte, SEQ_NONE if it is no lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] l;
    priority if ((b & 8'hf8) == 8'hf0) l = SEQ_LEN4;
    else if ((b & 8'hf0) == 8'he0)     l = SEQ_LEN3;
    else if ((b & 8'he0) == 8'hc0)     l = SEQ_LEN2;
    else                               l = SEQ_NONE;
    return l;
  endfunction

endpackage

// ===== design/utf8d_front.sv =====
module utf8d_front import utf8d_pkg::*; #(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF,
  localparam int CNW = $clog2(MAX_CHARS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       byte_value,
  input  logic             end_of_string,
  input  logic [CNW-1:0]   lim_m1,
  output logic             push,
  output utf8d_rec_t       rec
);

  // Sequence and limit state
  logic             pend_r, pend_nxt;
  logic [7:0]       lead_r, lead_nxt;
  logic [2:0]       len_r, len_nxt;
  logic [1:0]       gath_r, gath_nxt;
  logic [5:0]       cbuf_r [2];
  logic [CNW-1:0]   chars_r, chars_nxt;
  logic             hit_r, hit_nxt;
  logic             cbuf_we;

  logic             eos, is_cont, complete, fresh_open;
  logic [2:0]       f_len;
  logic [1:0]       n, nf;
  logic [7:0]       lead_data;
  logic [CP_W-1:0]  asm_cp;
  logic [CP_W-1:0]  chk_cp [MAX_RES];
  logic [2:0]       chk_n;
  logic             chk_open;
  logic [MAX_RES-1:0] live, pass;
  logic [2:0]       k;
  logic             fail, open_ok;

  assign eos        = end_of_string | (byte_value == 8'h00);
  assign is_cont    = (byte_value[7:6] == 2'b10);
  assign f_len      = lead_len(byte_value);
  assign fresh_open = (f_len != SEQ_NONE);
  assign lead_data  = lead_r & lead_mask(len_r);
  assign n          = (gath_r > 2'd2) ? 2'd2 : gath_r;
  assign nf         = n + 2'd1;
  assign complete   = ({1'b0, gath_r} + 3'd1) >= (len_r - 3'd1);

  // Code point of a finished sequence
  always_comb begin
    unique case (len_r)
      SEQ_LEN4: asm_cp = {lead_data[2:0], cbuf_r[0], cbuf_r[1], byte_value[5:0]};
      SEQ_LEN3: asm_cp = {5'd0, lead_data[3:0], cbuf_r[0], byte_value[5:0]};
      default:  asm_cp = {10'd0, lead_data[4:0], byte_value[5:0]};
    endcase
  end

  // Ordered list of room checks for this byte
  always_comb begin
    for (int j = 0; j < MAX_RES; j++) chk_cp[j] = '0;
    chk_n    = 3'd0;
    chk_open = 1'b0;
    if (eos) begin
      if (pend_r && !hit_r) begin
        chk_cp[0] = {13'd0, lead_data};
        chk_cp[1] = {13'd0, 2'b10, cbuf_r[0]};
        chk_cp[2] = {13'd0, 2'b10, cbuf_r[1]};
        chk_n     = {1'b0, nf};
      end
    end else if (!hit_r) begin
      if (pend_r && is_cont) begin
        if (complete) begin
          chk_cp[0] = asm_cp;
          chk_n     = 3'd1;
        end
      end else if (pend_r) begin
        chk_cp[0]  = {13'd0, lead_data};
        chk_cp[1]  = {13'd0, 2'b10, cbuf_r[0]};
        chk_cp[2]  = {13'd0, 2'b10, cbuf_r[1]};
        chk_cp[nf] = {13'd0, byte_value};
        chk_n      = {1'b0, nf} + 3'd1;
        chk_open   = fresh_open;
      end else begin
        chk_cp[0] = {13'd0, byte_value};
        chk_n     = 3'd1;
        chk_open  = fresh_open;
      end
    end
  end

  // Room checks: check j passes while chars_r plus j is below lim_m1
  always_comb begin
    k       = 3'd0;
    fail    = 1'b0;
    open_ok = 1'b0;
    for (int j = 0; j < MAX_RES; j++) begin
      live[j] = (3'(j) < chk_n);
      pass[j] = ({2'b00, chars_r} + (CNW+2)'(j)) < {2'b00, lim_m1};
      if (live[j] && !pass[j]) fail = 1'b1;
      if (live[j] && pass[j]) begin
        if (chk_open && (3'(j) == chk_n - 3'd1)) open_ok = 1'b1;
        else k = k + 3'd1;
      end
    end
  end

  // Result record
  always_comb begin
    for (int j = 0; j < MAX_RES; j++) rec.cp[j] = chk_cp[j];
    if (eos) begin
      rec.cp[k[1:0]] = '0;
      rec.cnt        = k + 3'd1;
      rec.last       = 1'b1;
    end else begin
      rec.cnt  = k;
      rec.last = 1'b0;
    end
    push = accept && (rec.cnt != 3'd0);
  end

  // Next state
  always_comb begin
    pend_nxt  = pend_r;
    lead_nxt  = lead_r;
    len_nxt   = len_r;
    gath_nxt  = gath_r;
    chars_nxt = CNW'({1'b0, chars_r} + (CNW+1)'(k));
    hit_nxt   = hit_r | fail;
    cbuf_we   = 1'b0;
    if (eos) begin
      pend_nxt  = 1'b0;
      len_nxt   = SEQ_NONE;
      gath_nxt  = 2'd0;
      chars_nxt = '0;
      hit_nxt   = 1'b0;
    end else if (hit_r || (pend_r && is_cont && complete)) begin
      pend_nxt = 1'b0;
      len_nxt  = SEQ_NONE;
      gath_nxt = 2'd0;
    end else if (pend_r && is_cont) begin
      cbuf_we  = 1'b1;
      gath_nxt = gath_r + 2'd1;
    end else begin
      pend_nxt = open_ok;
      lead_nxt = byte_value;
      len_nxt  = open_ok ? f_len : SEQ_NONE;
      gath_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      lead_r  <= 8'd0;
      len_r   <= SEQ_NONE;
      gath_r  <= 2'd0;
      chars_r <= '0;
      hit_r   <= 1'b0;
    end else if (accept) begin
      pend_r  <= pend_nxt;
      lead_r  <= lead_nxt;
      len_r   <= len_nxt;
      gath_r  <= gath_nxt;
      chars_r <= chars_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // Continuation byte buffer
  always_ff @(posedge clk) begin
    if (accept && cbuf_we) begin
      cbuf_r[gath_r[0]] <= byte_value[5:0];
    end
  end

endmodule

// ===== design/utf8d_queue.sv =====
module utf8d_queue import utf8d_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  utf8d_rec_t  push_rec,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output utf8d_rec_t  head_rec
);

  utf8d_rec_t       mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_rec = mem_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and fill count
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Record storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_rec;
    end
  end

endmodule

// ===== design/utf8d_back.sv =====
module utf8d_back import utf8d_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  utf8d_rec_t       q_rec,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [CP_W-1:0]  out_code_point,
  output logic             out_last
);

  // Record being unpacked and the output register
  utf8d_rec_t       cur_r;
  logic             cur_vld_r;
  logic [1:0]       idx_r;
  logic             ovld_r;
  logic [CP_W-1:0]  ocp_r;
  logic             olast_r;

  logic             out_rdy, adv, done, load;

  assign out_rdy = !ovld_r || out_pop;
  assign adv     = cur_vld_r && out_rdy;
  assign done    = adv && ({1'b0, idx_r} == cur_r.cnt - 3'd1);
  assign load    = (!cur_vld_r || done) && !q_empty;
  assign q_pop   = load;

  assign out_empty      = !ovld_r;
  assign out_code_point = ocp_r;
  assign out_last       = olast_r;

  // Unpacking control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 2'd0;
      ovld_r    <= 1'b0;
    end else begin
      if (load) begin
        cur_vld_r <= 1'b1;
        idx_r     <= 2'd0;
      end else if (done) begin
        cur_vld_r <= 1'b0;
      end else if (adv) begin
        idx_r <= idx_r + 2'd1;
      end
      if (adv)          ovld_r <= 1'b1;
      else if (out_pop) ovld_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) cur_r <= q_rec;
    if (adv) begin
      ocp_r   <= cur_r.cp[idx_r];
      olast_r <= cur_r.last && done;
    end
  end

endmodule

// ===== design/utf8_stream_decoder.sv =====
// UTF-8 byte stream to code point decoder. Push one byte per transaction; a
// transaction with in_end_of_string set, or a zero byte, ends the string and
// always yields a zero code point with out_last set. Complete 2, 3 and 4 byte
// sequences yield one code point each; broken sequences yield the masked lead
// and each gathered continuation byte raw, then the breaking byte is decoded
// anew. Stray bytes come out raw. At most cfg limit minus one characters are
// delivered per string (0 counts as 1, values above MAX_CHARS as MAX_CHARS);
// write the limit only while the block is idle. A byte is accepted every
// cycle while the 4-entry record queue has room; results leave at one per
// cycle while the receiver pops, so back-pressure from a byte that causes
// up to four results (a broken sequence) shows up as in_full when the
// record queue fills.
module utf8_stream_decoder import utf8d_pkg::*; #(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF,
  localparam int CNW = $clog2(MAX_CHARS),
  localparam int LW  = (CNW + 1 > 17) ? CNW + 1 : 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [7:0]       in_byte_value,
  input  logic             in_end_of_string,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [CP_W-1:0]  out_code_point,
  output logic             out_last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [16:0]      cfg_data
);

  // Clamped limit minus one
  function automatic logic [CNW-1:0] lim_m1(input logic [16:0] v);
    logic [LW-1:0] x;
    logic [LW-1:0] r;
    x = LW'(v);
    if (x == '0)                   r = '0;
    else if (x > LW'(MAX_CHARS))   r = LW'(MAX_CHARS - 1);
    else                           r = x - LW'(1);
    return r[CNW-1:0];
  endfunction

  logic [CNW-1:0] lim_m1_r;
  logic           accept, push, q_full, q_empty, q_pop;
  utf8d_rec_t     rec, head_rec;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_m1_r <= lim_m1(CFG_RESET);
    end else if (cfg_valid) begin
      lim_m1_r <= lim_m1(cfg_data);
    end
  end

  utf8d_front #(.MAX_CHARS(MAX_CHARS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .byte_value    (in_byte_value),
    .end_of_string (in_end_of_string),
    .lim_m1        (lim_m1_r),
    .push          (push),
    .rec           (rec)
  );

  utf8d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_rec (head_rec)
  );

  utf8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rec          (head_rec),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_code_point (out_code_point),
    .out_last       (out_last)
  );

endmodule

// ===== tb/sv/tb_utf8_stream_decoder.sv =====
module tb_utf8_stream_decoder;
  import utf8d_pkg::*;

  localparam int STALL_LIMIT = 5000;  // cycles with no transaction before giving up
  localparam int LONG_HOLD   = 300;   // receiver hold-off used to fill the block
  localparam int SETTLE      = 4;     // cycles past the last result before a cfg write

  // Directed bytes: ASCII extremes, all sequence lengths, strays, broken sequences
  localparam int N_DIR = 21;
  localparam logic [7:0] DIR_BYTES [N_DIR] = '{8'h41, 8'h7f, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac,
                                               8'hf0, 8'h9f, 8'h98, 8'h80, 8'h80, 8'hff, 8'hf8,
                                               8'he2, 8'h82, 8'h41, 8'hf0, 8'h90, 8'h80, 8'hc3};

  typedef enum int {POP_ALWAYS, POP_RANDOM, POP_ONE_IN_THREE, POP_MOSTLY} pop_pattern_e;

  // Decoder scoreboard: tracks sequence and limit state, holds expected characters
  class utf8_scoreboard;
    typedef struct {
      logic [CP_W-1:0] cp;
      logic            is_last;
    } char_t;

    char_t           exp_chars[$];
    logic [16:0]     limit_reg;
    bit              seq_open;
    logic [7:0]      lead_byte;
    logic [2:0]      seq_len;
    logic [1:0]      n_gathered;
    logic [5:0]      cont_bits[2];
    int unsigned     char_count;
    bit              limit_hit;
    int              errors;
    int              n_bytes;
    int              n_results;
    int              n_strings;

    function new();
      limit_reg  = CFG_RESET;
      char_count = 0;
      limit_hit  = 0;
      errors     = 0;
      n_bytes    = 0;
      n_results  = 0;
      n_strings  = 0;
      clear_seq();
    endfunction

    function void clear_seq();
      seq_open     = 0;
      lead_byte    = '0;
      seq_len      = '0;
      n_gathered   = '0;
      cont_bits[0] = '0;
      cont_bits[1] = '0;
    endfunction

    function void set_limit(logic [16:0] v);
      limit_reg = v;
    endfunction

    function int pending();
      return exp_chars.size();
    endfunction

    // Sticky check against limit minus one; 0 acts as 1, clamp at build max
    function bit has_room();
      int unsigned lim;
      lim = limit_reg;
      if (lim == 0) lim = 1;
      if (lim > MAX_CHARS_DEF) lim = MAX_CHARS_DEF;
      if (limit_hit || char_count >= lim - 1) begin
        limit_hit = 1;
        return 0;
      end
      return 1;
    endfunction

    function void queue_char(logic [CP_W-1:0] cp);
      char_t c;
      if (!has_room()) return;
      c.cp      = cp;
      c.is_last = 1'b0;
      exp_chars.push_back(c);
      char_count++;
    endfunction

    // Lead byte with its length marker stripped
    function logic [7:0] lead_bits();
      case (seq_len)
        3'd4:    return lead_byte & 8'h07;
        3'd3:    return lead_byte & 8'h0f;
        default: return lead_byte & 8'h1f;
      endcase
    endfunction

    // Broken sequence: masked lead, then each gathered continuation raw
    function void flush_open();
      int n;
      if (!seq_open) return;
      queue_char(CP_W'(lead_bits()));
      n = (n_gathered > 2) ? 2 : int'(n_gathered);
      for (int i = 0; i < n; i++) queue_char(CP_W'({2'b10, cont_bits[i]}));
      clear_seq();
    endfunction

    // Accepted input transaction: predict every character it causes
    function void note_byte(logic [7:0] b, logic eos_in);
      char_t           c;
      logic [CP_W-1:0] cp;
      logic [2:0]      len;
      int              n;
      n_bytes++;
      // zero byte counts as terminator too
      if (eos_in || b == 8'h00) begin
        if (!limit_hit) flush_open();
        c.cp      = '0;
        c.is_last = 1'b1;
        exp_chars.push_back(c);
        clear_seq();
        char_count = 0;
        limit_hit  = 0;
        n_strings++;
        return;
      end
      if (limit_hit) begin
        clear_seq();
        return;
      end
      if (seq_open) begin
        if (b[7:6] == 2'b10) begin
          if (int'(n_gathered) + 1 >= int'(seq_len) - 1) begin
            cp = CP_W'(lead_bits());
            n  = (n_gathered > 2) ? 2 : int'(n_gathered);
            for (int i = 0; i < n; i++) cp = (cp << 6) | CP_W'(cont_bits[i]);
            cp = (cp << 6) | CP_W'(b[5:0]);
            clear_seq();
            queue_char(cp);
          end else begin
            cont_bits[n_gathered[0]] = b[5:0];
            n_gathered++;
          end
          return;
        end
        flush_open();
      end
      // fresh byte: open a sequence or give it as is
      if (!has_room()) return;
      if (b[7:3] == 5'b11110)     len = 3'd4;
      else if (b[7:4] == 4'b1110) len = 3'd3;
      else if (b[7:5] == 3'b110)  len = 3'd2;
      else                        len = 3'd0;
      if (len != 0) begin
        seq_open   = 1;
        lead_byte  = b;
        seq_len    = len;
        n_gathered = '0;
      end else begin
        queue_char(CP_W'(b));
      end
    endfunction

    function void check_result(logic [CP_W-1:0] cp, logic lst);
      char_t c;
      n_results++;
      if (exp_chars.size() == 0) begin
        $error("unexpected result: code_point %0h last %0b", cp, lst);
        errors++;
        return;
      end
      c = exp_chars.pop_front();
      if (cp !== c.cp) begin
        $error("code_point: expected %0h, actual %0h", c.cp, cp);
        errors++;
      end
      if (lst !== c.is_last) begin
        $error("last: expected %0b, actual %0b", c.is_last, lst);
        errors++;
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_push = 1'b0;
  logic [7:0]      in_byte_value = 8'h00;
  logic            in_end_of_string = 1'b0;
  logic            out_pop = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [16:0]     cfg_data = 17'd0;
  logic            in_full;
  logic            out_empty;
  logic [CP_W-1:0] out_code_point;
  logic            out_last;
  logic            cfg_ready;

  utf8_scoreboard sb = new();

  int burst_left = 0;
  int n_cfg = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int rx_cyc = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  utf8_stream_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_byte_value    (in_byte_value),
    .in_end_of_string (in_end_of_string),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_code_point   (out_code_point),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // Receiver: rotating pop patterns, plus a long hold-off on request
  always @(posedge clk) begin
    rx_cyc++;
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_cnt  = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_pop <= 1'b0;
    end else begin
      case (pop_pattern_e'((rx_cyc / 50) % 4))
        POP_ALWAYS:       out_pop <= 1'b1;
        POP_RANDOM:       out_pop <= ($urandom_range(0, 1) == 1);
        POP_ONE_IN_THREE: out_pop <= (rx_cyc % 3 == 0);
        default:          out_pop <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_result(out_code_point, out_last);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One input transaction, then maybe a gap between bursts
  task automatic push_byte(logic [7:0] b, logic eos);
    int gap;
    in_push          <= 1'b1;
    in_byte_value    <= b;
    in_end_of_string <= eos;
    do @(posedge clk); while (in_full);
    sb.note_byte(b, eos);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(0, 12);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pauses until every expected character is out and the block settles
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [16:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
    n_cfg++;
  endtask

  function automatic logic [7:0] lead_for(int len);
    case (len)
      4:       return {5'b11110, 3'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      default: return {3'b110, 5'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // One character: mostly well formed, some truncated sequences and stray bytes
  task automatic send_char();
    int kind;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      push_byte(8'($urandom_range(1, 127)), 1'b0);
    end else if (kind < 80) begin
      len = $urandom_range(2, 4);
      push_byte(lead_for(len), 1'b0);
      repeat (len - 1) push_byte(cont_byte(), 1'b0);
    end else if (kind < 88) begin
      // truncated: a following non-continuation byte breaks it
      len = $urandom_range(2, 4);
      push_byte(lead_for(len), 1'b0);
      repeat ($urandom_range(0, len - 2)) push_byte(cont_byte(), 1'b0);
    end else if (kind < 94) begin
      push_byte(8'($urandom_range(8'h80, 8'hbf)), 1'b0);
    end else if (kind < 98) begin
      push_byte(8'($urandom_range(8'hf8, 8'hff)), 1'b0);
    end else begin
      push_byte(8'h00, 1'b0);
    end
  endtask

  // Random strings, each closed by a terminator, until target bytes are sent
  task automatic send_strings(int target, int max_len);
    int start;
    start = sb.n_bytes;
    while (sb.n_bytes - start < target) begin
      repeat ($urandom_range(1, max_len)) send_char();
      if ($urandom_range(0, 3) == 0) push_byte(8'h00, 1'b0);
      else push_byte(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ASCII extremes, all sequence lengths, strays, broken sequences
    for (int i = 0; i < N_DIR; i++) push_byte(DIR_BYTES[i], 1'b0);
    // terminator breaks the open two-byte lead; byte field ignored
    push_byte(8'hff, 1'b1);
    // zero byte alone ends an empty string
    push_byte(8'h00, 1'b0);

    // Receiver holds off while the sender keeps pushing
    write_limit(CFG_RESET);
    hold_requests++;
    send_strings(50, 12);

    write_limit(17'd1);
    send_strings(25, 6);
    write_limit(17'd0);
    send_strings(20, 6);
    write_limit(17'h1ffff);
    send_strings(30, 12);
    write_limit(17'd2);
    send_strings(25, 6);
    write_limit(17'd5);
    send_strings(40, 10);
    repeat (2) begin
      write_limit(17'($urandom_range(1, 16)));
      send_strings(20, 10);
    end
    write_limit(17'd65535);
    send_strings(30, 12);

    // Drain and let the block settle
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d bytes in %0d strings, %0d results checked, %0d limit writes",
             sb.n_bytes, sb.n_strings, sb.n_results, n_cfg);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
